// ===== design/lcc_pkg.sv =====
`default_nettype none

package lcc_pkg;

   localparam int CARD_WIDTH    = 63;
   localparam int MAX_DIGITS    = 19;
   localparam int BCD_DIGITS    = 19;
   localparam int BCD_WIDTH     = BCD_DIGITS * 4;
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS    = (CARD_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int PAD_WIDTH     = CONV_STEPS * BITS_PER_STEP;
   localparam int COUNT_WIDTH   = 5;

   localparam logic [1:0] TYPE_INVALID    = 2'd0;
   localparam logic [1:0] TYPE_VISA       = 2'd1;
   localparam logic [1:0] TYPE_AMEX       = 2'd2;
   localparam logic [1:0] TYPE_MASTERCARD = 2'd3;

   typedef struct packed {
      logic                   load;
      logic                   conv;
      logic                   scan;
      logic                   finish;
      logic [COUNT_WIDTH-1:0] index;
   } cmd_type;

endpackage

`default_nettype wire

// ===== design/luhn_card_number_classifier.sv =====
`default_nettype none

// Luhn card number classifier. An item is taken when start is high and busy
// is low; busy then stays high until the result is ready. The number is
// converted to decimal four bits a cycle, its 19 decimal digits are then
// walked one a cycle for the checksum, length and leading digits, and a
// final step classifies. rsp_valid then rises and stays high for one cycle,
// and busy drops in that same cycle, so a new item can be taken as soon as
// rsp_valid rises. The receiver cannot stall: the result is valid on the
// rsp_ ports while rsp_valid is high and is held there until the next result.

module luhn_card_number_classifier (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [lcc_pkg::CARD_WIDTH-1:0]  req_card_number,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_card_type,
   output logic                                 rsp_luhn_ok,
   output logic [lcc_pkg::COUNT_WIDTH-1:0]      rsp_digit_count
);
   import lcc_pkg::*;

   cmd_type cmd;

   lcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   lcc_datapath u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .card_number (req_card_number),
      .card_type   (rsp_card_type),
      .luhn_ok     (rsp_luhn_ok),
      .digit_count (rsp_digit_count)
   );

   a_type_needs_checksum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_card_type != TYPE_INVALID) |-> rsp_luhn_ok)
      else $error("card type given with failed checksum");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_count <= COUNT_WIDTH'(MAX_DIGITS)))
      else $error("digit count beyond limit");

   a_type_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_card_type != TYPE_INVALID) |->
         (rsp_digit_count == 5'd13 || rsp_digit_count == 5'd15 ||
          rsp_digit_count == 5'd16))
      else $error("card type given for an impossible length");

endmodule

`default_nettype wire

// ===== design/lcc_ctrl.sv =====
`default_nettype none

module lcc_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   output logic                 rsp_valid,
   output lcc_pkg::cmd_type     cmd
);
   import lcc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam logic [COUNT_WIDTH-1:0] CONV_LAST = COUNT_WIDTH'(CONV_STEPS - 1);
   localparam logic [COUNT_WIDTH-1:0] SCAN_LAST = COUNT_WIDTH'(BCD_DIGITS - 1);

   logic [1:0]             state_ff, state_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                   valid_ff, valid_in;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      valid_in   = 1'b0;
      cmd.load   = 1'b0;
      cmd.conv   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.finish = 1'b0;
      cmd.index  = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv = 1'b1;
            if (cnt_ff == CONV_LAST) begin
               cnt_in   = '0;
               state_in = ST_SCAN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (cnt_ff == SCAN_LAST) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            valid_in   = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

   a_start_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

endmodule

`default_nettype wire

// ===== design/lcc_datapath.sv =====
`default_nettype none

module lcc_datapath (
   input  wire logic                            clock,
   input  wire lcc_pkg::cmd_type                cmd,
   input  wire logic [lcc_pkg::CARD_WIDTH-1:0]  card_number,
   output logic [1:0]                           card_type,
   output logic                                 luhn_ok,
   output logic [lcc_pkg::COUNT_WIDTH-1:0]      digit_count
);
   import lcc_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] MAX_COUNT = COUNT_WIDTH'(MAX_DIGITS);

   logic [PAD_WIDTH-1:0]   bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [3:0]             sum_ff, sum_in;
   logic [3:0]             prev_ff, prev_in;
   logic [3:0]             top_ff, top_in;
   logic [3:0]             next_ff, next_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic [1:0]             type_ff, type_in;
   logic                   ok_ff, ok_in;
   logic [COUNT_WIDTH-1:0] dcnt_ff, dcnt_in;

   logic [BCD_WIDTH+PAD_WIDTH-1:0] dabble;
   logic [3:0]             digit;
   logic [4:0]             dbl;
   logic [3:0]             contrib;
   logic [4:0]             sum_raw;
   logic [COUNT_WIDTH-1:0] count_fin;
   logic                   in_range;

   // shift-and-add-3 binary to BCD, BITS_PER_STEP bits per cycle
   always_comb begin
      dabble = {bcd_ff, bin_ff};
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         for (int k = 0; k < BCD_DIGITS; k++) begin
            if (dabble[PAD_WIDTH + 4*k +: 4] >= 4'd5) begin
               dabble[PAD_WIDTH + 4*k +: 4] = dabble[PAD_WIDTH + 4*k +: 4] + 4'd3;
            end
         end
         dabble = dabble << 1;
      end
   end

   assign digit    = bcd_ff[3:0];
   assign dbl      = {digit, 1'b0};
   assign contrib  = cmd.index[0] ? ((dbl >= 5'd10) ? 4'(dbl - 5'd9) : dbl[3:0]) : digit;
   assign sum_raw  = {1'b0, sum_ff} + {1'b0, contrib};
   assign in_range = (cmd.index < MAX_COUNT);
   assign count_fin = ovf_ff ? MAX_COUNT : count_ff;

   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      sum_in   = sum_ff;
      prev_in  = prev_ff;
      top_in   = top_ff;
      next_in  = next_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      type_in  = type_ff;
      ok_in    = ok_ff;
      dcnt_in  = dcnt_ff;
      if (cmd.load) begin
         bin_in   = {{(PAD_WIDTH-CARD_WIDTH){1'b0}}, card_number};
         bcd_in   = '0;
         sum_in   = '0;
         prev_in  = '0;
         top_in   = '0;
         next_in  = '0;
         count_in = '0;
         ovf_in   = 1'b0;
      end
      if (cmd.conv) begin
         bcd_in = dabble[PAD_WIDTH +: BCD_WIDTH];
         bin_in = dabble[PAD_WIDTH-1:0];
      end
      if (cmd.scan) begin
         bcd_in  = bcd_ff >> 4;
         prev_in = digit;
         if (in_range) begin
            sum_in = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
            if (digit != 4'd0) begin
               count_in = cmd.index + 1'b1;
               top_in   = digit;
               next_in  = prev_ff;
            end
         end else if (digit != 4'd0) begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.finish) begin
         ok_in   = (sum_ff == 4'd0);
         dcnt_in = count_fin;
         type_in = TYPE_INVALID;
         if (!ovf_ff && (sum_ff == 4'd0)) begin
            case (count_ff)
               COUNT_WIDTH'(13): begin
                  if (top_ff == 4'd4) type_in = TYPE_VISA;
               end
               COUNT_WIDTH'(15): begin
                  if (top_ff == 4'd3 && (next_ff == 4'd4 || next_ff == 4'd7)) begin
                     type_in = TYPE_AMEX;
                  end
               end
               COUNT_WIDTH'(16): begin
                  if (top_ff == 4'd4) begin
                     type_in = TYPE_VISA;
                  end else if (top_ff == 4'd5 && next_ff >= 4'd1 && next_ff <= 4'd5) begin
                     type_in = TYPE_MASTERCARD;
                  end
               end
               default: begin
                  type_in = TYPE_INVALID;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      sum_ff   <= sum_in;
      prev_ff  <= prev_in;
      top_ff   <= top_in;
      next_ff  <= next_in;
      count_ff <= count_in;
      ovf_ff   <= ovf_in;
      type_ff  <= type_in;
      ok_ff    <= ok_in;
      dcnt_ff  <= dcnt_in;
   end

   assign card_type   = type_ff;
   assign luhn_ok     = ok_ff;
   assign digit_count = dcnt_ff;

endmodule

`default_nettype wire
